>>> rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Types and constants shared by the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sitoa_pkg;

	localparam int IN_W       = 32;
	localparam int MAX_DIGITS = 10;
	localparam int BCD_W      = 4 * MAX_DIGITS;
	localparam int POS_W      = $clog2(MAX_DIGITS);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef logic [BCD_W-1:0] bcd_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} sitoa_state_t;

endpackage

>>> rtl/sitoa_in_if.sv
// ----------------------------------------------------------------------------
// sitoa_in_if
// Valid/ready channel that carries one signed integer per transaction.
// ----------------------------------------------------------------------------
interface sitoa_in_if
	import sitoa_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/sitoa_out_if.sv
// ----------------------------------------------------------------------------
// sitoa_out_if
// Valid/ready channel that carries one ASCII character per transaction.
// ----------------------------------------------------------------------------
interface sitoa_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed integer to decimal ASCII text, one character per cycle
// while the receiver is ready, most significant first, with a leading '-'
// for negative values. Steps: accept, conversion of W bits (W =
// min(VALUE_WIDTH, 32), one bit per cycle through the shared shift-and-add-3
// unit), scan, then emission. A new integer is taken only after the last
// character. Reset returns to idle, ready for input.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
	import sitoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	sitoa_in_if.sink      operand,
	sitoa_out_if.source   result
);

	localparam int EW    = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;
	localparam int CNT_W = $clog2(EW + 1);
	localparam logic [CNT_W-1:0] EW_C = CNT_W'(EW);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	sitoa_state_t     state_q, state_d;
	logic [EW-1:0]    mag_q;
	logic [CNT_W-1:0] bit_cnt_q;
	bcd_t             bcd_q;
	bcd_t             bcd_next;
	pos_t             pos_q;
	pos_t             top_pos;
	logic             neg_q;
	logic [EW-1:0]    v_low;
	logic             accept_in;
	logic             accept_out;

	assign v_low      = operand.value[EW-1:0];
	assign accept_in  = operand.valid && operand.ready;
	assign accept_out = result.valid && result.ready;

	sitoa_dabble u_dabble (
		.bcd      (bcd_q),
		.bit_in   (mag_q[EW-1]),
		.bcd_next (bcd_next)
	);

	always_comb begin
		top_pos = '0;
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				top_pos = POS_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (bit_cnt_q == ONE_C) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (accept_out && !neg_q && pos_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		operand.ready    = (state_q == ST_IDLE);
		result.valid     = (state_q == ST_EMIT);
		result.character = neg_q ? CHAR_MINUS : (CHAR_ZERO + {4'd0, bcd_q[pos_q*4 +: 4]});
		result.last      = !neg_q && (pos_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			pos_q     <= '0;
			neg_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						neg_q     <= v_low[EW-1];
						bit_cnt_q <= EW_C;
					end
				end
				ST_CONV: bit_cnt_q <= bit_cnt_q - ONE_C;
				ST_SCAN: pos_q <= top_pos;
				ST_EMIT: begin
					if (accept_out) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else if (pos_q != '0) begin
							pos_q <= pos_q - POS_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			bcd_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						mag_q <= v_low[EW-1] ? (~v_low + EW'(1)) : v_low;
						bcd_q <= '0;
					end
				end
				ST_CONV: begin
					bcd_q <= bcd_next;
					mag_q <= {mag_q[EW-2:0], 1'b0};
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/sitoa_dabble.sv
// ----------------------------------------------------------------------------
// sitoa_dabble
// One shift-and-add-3 step of binary to BCD conversion over all digits.
// ----------------------------------------------------------------------------
module sitoa_dabble
	import sitoa_pkg::*;
(
	input  bcd_t bcd,
	input  logic bit_in,
	output bcd_t bcd_next
);

	bcd_t adj;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd[4*i +: 4];
			end
		end
	end

	assign bcd_next = {adj[BCD_W-2:0], bit_in};

endmodule

>>> test/tb_signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core
// Sends signed 32-bit integers into the core and checks every returned ASCII
// character and its last flag against a local decimal text predictor. Covers
// corner values, numbers of every length and sign, random gaps on both
// channels, a long receiver hold-off and a sender pause that drains the core.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_core;
	import sitoa_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 190;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		logic [IN_W-1:0] value;
		int              gap;
		bit              drain_first;
	} number_item_t;

	typedef struct {
		logic [7:0] character;
		logic       last;
	} text_char_t;

	logic clk = 1'b0;
	logic arst_n;

	sitoa_in_if  operand_if ();
	sitoa_out_if result_if ();

	signed_int_to_decimal_ascii_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_if),
		.result (result_if)
	);

	number_item_t number_queue[$];
	text_char_t   text_queue[$];
	number_item_t next_item;

	int fail_count;
	int accepted_numbers;
	int send_wait;
	int send_calm;
	int take_wait;
	int take_calm;
	int hold_left;
	bit hold_done;
	int stall_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		fail_count++;
	endtask

	// decimal text of one number, most significant character first
	function automatic void queue_text(logic [IN_W-1:0] value);
		logic [63:0] magnitude;
		logic [3:0]  digits[$];
		bit          negative;
		text_char_t  c;
		negative = value[IN_W-1];
		magnitude = negative ? ({32'd0, ~value} + 64'd1) : {32'd0, value};
		do begin
			digits.push_front(4'(magnitude % 64'd10));
			magnitude = magnitude / 64'd10;
		end while (magnitude != 64'd0);
		if (negative) begin
			c.character = CHAR_MINUS;
			c.last = 1'b0;
			text_queue.push_back(c);
		end
		foreach (digits[i]) begin
			c.character = CHAR_ZERO + 8'(digits[i]);
			c.last = (i == digits.size() - 1);
			text_queue.push_back(c);
		end
	endfunction

	function automatic void add_number(logic [IN_W-1:0] value, bit drain_first);
		number_item_t item;
		item.value = value;
		item.drain_first = drain_first;
		if (send_calm > 0) begin
			item.gap = 0;
			send_calm--;
		end else begin
			item.gap = pick_gap();
			if ($urandom_range(0, 24) == 0)
				send_calm = $urandom_range(10, 25);
		end
		number_queue.push_back(item);
	endfunction

	// operand driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_if.valid <= 1'b0;
			operand_if.value <= '0;
			send_wait <= 0;
		end else if (!operand_if.valid || operand_if.ready) begin
			if (send_wait > 0) begin
				operand_if.valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (number_queue.size() == 0 || (number_queue[0].drain_first &&
					(operand_if.valid || text_queue.size() != 0))) begin
				operand_if.valid <= 1'b0;
			end else begin
				next_item = number_queue.pop_front();
				operand_if.valid <= 1'b1;
				operand_if.value <= next_item.value;
				send_wait <= next_item.gap;
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_numbers == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result ready driver
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			take_wait <= 0;
			take_calm = 0;
		end else if (hold_left > 0) begin
			result_if.ready <= 1'b0;
		end else if (take_wait > 0) begin
			result_if.ready <= 1'b0;
			take_wait <= take_wait - 1;
		end else if (result_if.valid && result_if.ready) begin
			if (take_calm > 0) begin
				g = 0;
				take_calm--;
			end else begin
				g = pick_gap();
				if ($urandom_range(0, 49) == 0)
					take_calm = $urandom_range(30, 80);
			end
			result_if.ready <= (g == 0);
			take_wait <= (g > 0) ? g - 1 : 0;
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	// monitor: check results, then predict for the accepted number
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			accepted_numbers <= 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (text_queue.size() == 0) begin
					report_mismatch($sformatf("character 0x%02h with nothing expected",
						result_if.character));
				end else begin
					want = text_queue.pop_front();
					if (result_if.character !== want.character)
						report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
							result_if.character, want.character));
					if (result_if.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b on character 0x%02h",
							result_if.last, want.last, want.character));
				end
			end
			if (operand_if.valid && operand_if.ready) begin
				queue_text(operand_if.value);
				accepted_numbers <= accepted_numbers + 1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (operand_if.valid && operand_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int          corner_values[22];
		int          r;
		int          d;
		longint      mag;
		longint      lo;
		longint      hi;
		logic [31:0] v;
		corner_values = '{0, 1, -1, 9, 10, -9, -10, 99, 100, -100,
			2147483647, 32'h80000000, -2147483647, 1000000000, 999999999,
			-1000000000, -999999999, 1234567890, -123456789, 32'h55555555,
			32'hAAAAAAAA, 32'h7FFFFFFE};
		arst_n = 1'b0;
		operand_if.valid = 1'b0;
		operand_if.value = '0;
		result_if.ready = 1'b0;
		fail_count = 0;
		send_calm = 0;
		stall_cycles = 0;

		foreach (corner_values[i])
			add_number(corner_values[i], 1'b0);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				v = $urandom;
			end else if (r < 80) begin
				d = $urandom_range(1, 10);
				lo = (d == 1) ? 0 : 10 ** (d - 1);
				hi = (d == 10) ? 64'd2147483647 : (10 ** d) - 1;
				mag = lo + ($urandom % (hi - lo + 1));
				v = $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
			end else begin
				mag = (10 ** $urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
				v = $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
			end
			add_number(v, n == 120);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (number_queue.size() != 0 || operand_if.valid || text_queue.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (fail_count == 0 && text_queue.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
